>>> sv/mch_pkg.sv
// Shared types, codes and constants of the magnetometer compass heading unit.
// Holds the arctangent table of the CORDIC cells and the heading scaling constants.
// Depends on nothing; every other file refers to it by scoped names.
package mch_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_X_MAX        = 3'd0,
        REG_X_MIN        = 3'd1,
        REG_Y_MAX        = 3'd2,
        REG_Y_MIN        = 3'd3,
        REG_HEADING_ZERO = 3'd4
    } t_cfg_index;

    localparam int SAMPLE_W  = 16;
    localparam int HEADING_W = 12;
    localparam int CFG_IDX_W = 3;

    // Angle accumulator: radians with 30 fraction bits, sign plus 32 magnitude bits.
    localparam int Z_W   = 33;
    localparam int MAG_W = 32;

    // One-pole smoothing filter, f = (55706 f + 9830 v) / 65536.
    localparam logic signed [16:0] COEF_KEEP  = 17'sd55706;
    localparam logic signed [16:0] COEF_NEW   = 17'sd9830;
    localparam int                 COEF_SHIFT = 16;

    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 33'sd1686629713;

    // Scaling to tenths of a degree: p = mag * 572968 / 2^30, tenths = p / 1000.
    localparam int              P_W         = 21;
    localparam int              Q_W         = 12;
    localparam logic [19:0]     SCALE_NUM   = 20'd572968;
    localparam int              SCALE_SHIFT = 30;
    localparam logic [22:0]     RECIP_1000  = 23'd4294967;
    localparam int              RECIP_SHIFT = 32;
    localparam logic [10:0]     DIVISOR     = 11'd1000;

    // Heading arithmetic runs in 14 bits.
    localparam int          H_W       = 14;
    localparam logic [13:0] OFFSET    = 14'd7200;
    localparam logic [13:0] FULL_TURN = 14'd3600;
    localparam logic [13:0] TWO_TURNS = 14'd7200;

    // floor(atan(2^-i) * 2^30)
    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] val;
        unique case (idx)
            0:       val = 32'h3243F6A8;
            1:       val = 32'h1DAC6705;
            2:       val = 32'h0FADBAFC;
            3:       val = 32'h07F56EA6;
            4:       val = 32'h03FEAB76;
            5:       val = 32'h01FFD55B;
            6:       val = 32'h00FFFAAA;
            7:       val = 32'h007FFF55;
            8:       val = 32'h003FFFEA;
            9:       val = 32'h001FFFFD;
            10:      val = 32'h000FFFFF;
            11:      val = 32'h0007FFFF;
            12:      val = 32'h0003FFFF;
            13:      val = 32'h0001FFFF;
            14:      val = 32'h0000FFFF;
            15:      val = 32'h00007FFF;
            16:      val = 32'h00003FFF;
            17:      val = 32'h00001FFF;
            18:      val = 32'h00000FFF;
            19:      val = 32'h000007FF;
            20:      val = 32'h000003FF;
            21:      val = 32'h000001FF;
            22:      val = 32'h000000FF;
            23:      val = 32'h0000007F;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

>>> sv/mch_filter.sv
// Hard-iron correction and one-pole smoothing of both axes, first stage of the pipeline.
// The smoothed values are the block's state and double as this stage's payload.
// Depends on mch_pkg.
module mch_filter #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [mch_pkg::SAMPLE_W-1:0]   i_mag_x,
    input  logic signed [mch_pkg::SAMPLE_W-1:0]   i_mag_y,
    input  logic signed [mch_pkg::SAMPLE_W:0]     i_x_sum,
    input  logic signed [mch_pkg::SAMPLE_W:0]     i_y_sum,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [FRAC_BITS+17:0]          o_sx,
    output logic signed [FRAC_BITS+17:0]          o_sy
);

    localparam int SW = FRAC_BITS + 18;
    localparam int VW = FRAC_BITS + 17;
    localparam int AW = SW + 17;

    logic                 r_v;
    logic signed [SW-1:0] r_sx, r_sy;
    logic signed [SW-1:0] n_sx, n_sy;
    logic signed [17:0]   d_x, d_y;
    logic signed [VW-1:0] v_x, v_y;
    logic signed [AW-1:0] acc_x, acc_y;

    // v = raw * 2^F - (max + min) * 2^(F-1) = (2 raw - (max + min)) * 2^(F-1), exact.
    assign d_x = {i_mag_x[mch_pkg::SAMPLE_W-1], i_mag_x, 1'b0} - {i_x_sum[mch_pkg::SAMPLE_W], i_x_sum};
    assign d_y = {i_mag_y[mch_pkg::SAMPLE_W-1], i_mag_y, 1'b0} - {i_y_sum[mch_pkg::SAMPLE_W], i_y_sum};
    assign v_x = {d_x, {(FRAC_BITS-1){1'b0}}};
    assign v_y = {d_y, {(FRAC_BITS-1){1'b0}}};

    assign acc_x = AW'(mch_pkg::COEF_KEEP) * AW'(r_sx) + AW'(mch_pkg::COEF_NEW) * AW'(v_x);
    assign acc_y = AW'(mch_pkg::COEF_KEEP) * AW'(r_sy) + AW'(mch_pkg::COEF_NEW) * AW'(v_y);

    // The arithmetic shift rounds toward minus infinity.
    assign n_sx = SW'(acc_x >>> mch_pkg::COEF_SHIFT);
    assign n_sy = SW'(acc_y >>> mch_pkg::COEF_SHIFT);

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_sx    = r_sx;
    assign o_sy    = r_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= 1'b0;
            r_sx <= '0;
            r_sy <= '0;
        end else begin
            if (o_ready) begin
                r_v <= i_valid;
            end
            if (i_valid && o_ready) begin
                r_sx <= n_sx;
                r_sy <= n_sy;
            end
        end
    end

endmodule

>>> sv/mch_cordic_cell.sv
// One vectoring CORDIC step as a pipeline cell with its own valid and ready.
// The step index fixes the shift and the arctangent constant of the cell.
// Depends on mch_pkg.
module mch_cordic_cell #(
    parameter int CW   = 36,
    parameter int STEP = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [CW-1:0]              i_x,
    input  logic signed [CW-1:0]              i_y,
    input  logic signed [mch_pkg::Z_W-1:0]    i_z,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [CW-1:0]              o_x,
    output logic signed [CW-1:0]              o_y,
    output logic signed [mch_pkg::Z_W-1:0]    o_z
);

    logic                             r_v;
    logic signed [CW-1:0]             r_x, r_y;
    logic signed [mch_pkg::Z_W-1:0]   r_z;
    logic signed [CW-1:0]             dx, dy, n_x, n_y;
    logic signed [mch_pkg::Z_W-1:0]   atan_z, n_z;

    assign atan_z = mch_pkg::Z_W'(mch_pkg::atan_q30(STEP));
    assign dx     = i_y >>> STEP;
    assign dy     = i_x >>> STEP;

    // Turn the vector towards the positive x axis.
    always_comb begin
        if (!i_y[CW-1]) begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + atan_z;
        end else begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - atan_z;
        end
    end

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

endmodule

>>> sv/mch_scale.sv
// Converts the CORDIC angle to tenths of a degree and applies the reference heading.
// Five stages: magnitude, scaling product, reciprocal quotient, correction, wrap and output.
// Depends on mch_pkg.
module mch_scale (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [mch_pkg::Z_W-1:0]       i_z,
    input  logic                                 i_null,
    input  logic [mch_pkg::HEADING_W-1:0]        i_zero,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [mch_pkg::HEADING_W-1:0]        o_heading
);

    localparam int PB_W = mch_pkg::MAG_W + 20;
    localparam int PC_W = mch_pkg::P_W + 23;
    localparam int R_W  = mch_pkg::P_W + 1;

    logic r_a_v, r_b_v, r_c_v, r_d_v, r_e_v;
    logic rdy_b, rdy_c, rdy_d, rdy_e;

    logic                          r_a_neg, r_b_neg, r_c_neg, r_d_neg;
    logic [mch_pkg::MAG_W-1:0]     r_a_mag, n_a_mag;
    logic [mch_pkg::P_W-1:0]       r_b_p, r_c_p;
    logic [mch_pkg::Q_W-1:0]       r_c_q, r_d_q, n_d_q;
    logic [mch_pkg::HEADING_W-1:0] r_e_heading, n_e_heading;
    logic                          n_a_neg;
    logic [PB_W-1:0]               prod_b;
    logic [PC_W-1:0]               prod_c;
    logic [R_W-1:0]                rem;
    logic [mch_pkg::H_W-1:0]       sum_h;

    assign rdy_e   = !r_e_v || i_ready;
    assign rdy_d   = !r_d_v || rdy_e;
    assign rdy_c   = !r_c_v || rdy_d;
    assign rdy_b   = !r_b_v || rdy_c;
    assign o_ready = !r_a_v || rdy_b;

    // A zero vector gives angle zero.
    assign n_a_neg = i_z[mch_pkg::Z_W-1] && !i_null;
    assign n_a_mag = i_null ? '0 :
                     (i_z[mch_pkg::Z_W-1] ? mch_pkg::MAG_W'(-i_z) : i_z[mch_pkg::MAG_W-1:0]);

    assign prod_b = PB_W'(r_a_mag) * PB_W'(mch_pkg::SCALE_NUM);
    assign prod_c = PC_W'(r_b_p) * PC_W'(mch_pkg::RECIP_1000);

    // The reciprocal quotient is exact or one short.
    assign rem   = R_W'(r_c_p) - R_W'(r_c_q) * R_W'(mch_pkg::DIVISOR);
    assign n_d_q = (rem >= R_W'(mch_pkg::DIVISOR)) ? r_c_q + mch_pkg::Q_W'(1) : r_c_q;

    // The sum lies between a third of a turn and three turns, so two compares wrap it.
    assign sum_h = r_d_neg ?
                   mch_pkg::OFFSET - mch_pkg::H_W'(r_d_q) - mch_pkg::H_W'(i_zero) :
                   mch_pkg::OFFSET + mch_pkg::H_W'(r_d_q) - mch_pkg::H_W'(i_zero);

    always_comb begin
        priority if (sum_h >= mch_pkg::TWO_TURNS) begin
            n_e_heading = mch_pkg::HEADING_W'(sum_h - mch_pkg::TWO_TURNS);
        end else if (sum_h >= mch_pkg::FULL_TURN) begin
            n_e_heading = mch_pkg::HEADING_W'(sum_h - mch_pkg::FULL_TURN);
        end else begin
            n_e_heading = mch_pkg::HEADING_W'(sum_h);
        end
    end

    assign o_valid   = r_e_v;
    assign o_heading = r_e_heading;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else begin
            if (o_ready) r_a_v <= i_valid;
            if (rdy_b)   r_b_v <= r_a_v;
            if (rdy_c)   r_c_v <= r_b_v;
            if (rdy_d)   r_d_v <= r_c_v;
            if (rdy_e)   r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_a_neg <= n_a_neg;
            r_a_mag <= n_a_mag;
        end
        if (r_a_v && rdy_b) begin
            r_b_neg <= r_a_neg;
            r_b_p   <= prod_b[mch_pkg::SCALE_SHIFT+mch_pkg::P_W-1:mch_pkg::SCALE_SHIFT];
        end
        if (r_b_v && rdy_c) begin
            r_c_neg <= r_b_neg;
            r_c_p   <= r_b_p;
            r_c_q   <= prod_c[mch_pkg::RECIP_SHIFT+mch_pkg::Q_W-1:mch_pkg::RECIP_SHIFT];
        end
        if (r_c_v && rdy_d) begin
            r_d_neg <= r_c_neg;
            r_d_q   <= n_d_q;
        end
        if (r_d_v && rdy_e) begin
            r_e_heading <= n_e_heading;
        end
    end

endmodule

>>> sv/magnetometer_compass_heading_unit.sv
// Top level of the magnetometer compass heading unit.
// Instantiates mch_filter, a row of mch_cordic_cell and mch_scale; uses mch_pkg.
//
// Usage. Each item on the input channel (i_in_valid, o_in_ready, i_mag_x, i_mag_y) is one
// raw X/Y magnetometer sample pair. For every item the block delivers exactly one item on
// the output channel (o_out_valid, i_out_ready, o_heading): the heading relative to the
// programmed reference, 0 to 3599 tenths of a degree. The configuration channel
// (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data) writes the calibration extremes
// and the reference heading; it is always ready and should be used while the block is
// idle. Unknown indexes are ignored.
// Path. The filter register is loaded at the edge that accepts an item; after that
// the item passes through each CORDIC cell register and then the registers of the
// scaling unit, the last of which is the output register.
// Throughput. One item per cycle while the receiver is ready. Every stage has its own valid
// bit and ready, so a stalled receiver only fills the pipeline; new items are still taken
// until all CORDIC_STEPS + 6 stages hold an item.
// Reset. A synchronous active-low reset clears the configuration registers, the
// smoothed axis values and every valid bit; no clearing pass is needed.
module magnetometer_compass_heading_unit #(
    parameter int FRACTION_BITS = 16,
    parameter int CORDIC_STEPS  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [mch_pkg::SAMPLE_W-1:0]   i_mag_x,
    input  logic signed [mch_pkg::SAMPLE_W-1:0]   i_mag_y,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [mch_pkg::HEADING_W-1:0]         o_heading,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mch_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [mch_pkg::SAMPLE_W-1:0]          i_cfg_data
);

    // Smoothed state width, and two guard bits for the CORDIC gain.
    localparam int SW = FRACTION_BITS + 18;
    localparam int CW = SW + 2;

    logic signed [mch_pkg::SAMPLE_W-1:0]  r_x_max, r_x_min, r_y_max, r_y_min;
    logic [mch_pkg::HEADING_W-1:0]        r_heading_zero;
    logic signed [mch_pkg::SAMPLE_W:0]    x_sum, y_sum;

    logic                                 filt_valid;
    logic signed [SW-1:0]                 filt_sx, filt_sy;
    logic signed [CW-1:0]                 sx_ext, sy_ext;
    logic signed [CW-1:0]                 c_x0, c_y0;
    logic signed [mch_pkg::Z_W-1:0]       c_z0;

    logic signed [CW-1:0]                 w_x [CORDIC_STEPS+1];
    logic signed [CW-1:0]                 w_y [CORDIC_STEPS+1];
    logic signed [mch_pkg::Z_W-1:0]       w_z [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0]                w_v, w_rdy;
    logic                                 w_null;

    // Configuration registers; writes are never refused.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_max        <= '0;
            r_x_min        <= '0;
            r_y_max        <= '0;
            r_y_min        <= '0;
            r_heading_zero <= '0;
        end else if (i_cfg_valid) begin
            unique case (mch_pkg::t_cfg_index'(i_cfg_index))
                mch_pkg::REG_X_MAX:        r_x_max        <= i_cfg_data;
                mch_pkg::REG_X_MIN:        r_x_min        <= i_cfg_data;
                mch_pkg::REG_Y_MAX:        r_y_max        <= i_cfg_data;
                mch_pkg::REG_Y_MIN:        r_y_min        <= i_cfg_data;
                mch_pkg::REG_HEADING_ZERO: r_heading_zero <= i_cfg_data[mch_pkg::HEADING_W-1:0];
                default: ;
            endcase
        end
    end

    // Twice the hard-iron centre of each axis.
    assign x_sum = {r_x_max[mch_pkg::SAMPLE_W-1], r_x_max} + {r_x_min[mch_pkg::SAMPLE_W-1], r_x_min};
    assign y_sum = {r_y_max[mch_pkg::SAMPLE_W-1], r_y_max} + {r_y_min[mch_pkg::SAMPLE_W-1], r_y_min};

    mch_filter #(
        .FRAC_BITS (FRACTION_BITS)
    ) u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_mag_x (i_mag_x),
        .i_mag_y (i_mag_y),
        .i_x_sum (x_sum),
        .i_y_sum (y_sum),
        .o_valid (filt_valid),
        .i_ready (w_rdy[0]),
        .o_sx    (filt_sx),
        .o_sy    (filt_sy)
    );

    // A vector in the left half-plane is first turned by a quarter turn, so that the
    // CORDIC cells only ever see x >= 0 and the angle can reach close to a half turn.
    assign sx_ext = CW'(filt_sx);
    assign sy_ext = CW'(filt_sy);

    always_comb begin
        if (sx_ext[CW-1]) begin
            if (!sy_ext[CW-1]) begin
                c_x0 = sy_ext;
                c_y0 = -sx_ext;
                c_z0 = mch_pkg::HALF_PI_Q30;
            end else begin
                c_x0 = -sy_ext;
                c_y0 = sx_ext;
                c_z0 = -mch_pkg::HALF_PI_Q30;
            end
        end else begin
            c_x0 = sx_ext;
            c_y0 = sy_ext;
            c_z0 = '0;
        end
    end

    assign w_x[0] = c_x0;
    assign w_y[0] = c_y0;
    assign w_z[0] = c_z0;
    assign w_v[0] = filt_valid;

    // The row of CORDIC cells: cell g performs rotation step g and hands its vector on.
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        mch_cordic_cell #(
            .CW   (CW),
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[g]),
            .o_ready (w_rdy[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .o_valid (w_v[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1])
        );
    end

    // x never decreases through the cells and is positive after the first one unless the
    // vector was zero from the start, so a zero x at the end of the row marks a zero vector.
    assign w_null = (w_x[CORDIC_STEPS] == '0);

    mch_scale u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_v[CORDIC_STEPS]),
        .o_ready   (w_rdy[CORDIC_STEPS]),
        .i_z       (w_z[CORDIC_STEPS]),
        .i_null    (w_null),
        .i_zero    (r_heading_zero),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_heading (o_heading)
    );

`ifndef NO_ASSERTIONS
    // A delivered heading always lies within one turn.
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_heading < mch_pkg::HEADING_W'(3600)))
        else $error("heading outside one turn");

    // An accepted item is held by the filter stage in the next cycle.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> filt_valid)
        else $error("accepted item lost in filter stage");

    // Input is refused only when the filter stage holds an item that cannot move on.
    a_refuse_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (filt_valid && !w_rdy[0]))
        else $error("input refused with room in the pipeline");

    // A write to the X maximum register takes effect at once.
    a_cfg_x_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && (i_cfg_index == mch_pkg::REG_X_MAX)) |=> (r_x_max == $past(i_cfg_data)))
        else $error("X maximum register not written");
`endif

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the magnetometer compass heading unit.
// Depends on mch_pkg for the sample, heading and register index widths and the register indexes, and on the top level.
// Drives samples and calibration writes, predicts every heading and checks it in order.
module tb_top;

    // Field widths of the unit.
    localparam int SAMPLE_W  = mch_pkg::SAMPLE_W;
    localparam int HEADING_W = mch_pkg::HEADING_W;
    localparam int CFG_IDX_W = mch_pkg::CFG_IDX_W;

    // Timing of the run.
    localparam int PIPE_LATENCY   = 22;     // from acceptance to the earliest handover
    localparam int WATCHDOG_LIMIT = 1000;   // cycles with no handshake at all

    // Stimulus sizing.
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int NO_CHECK        = -1;

    // Field extremes.
    localparam int SAMPLE_MAX   = 32767;
    localparam int SAMPLE_MIN   = -32768;
    localparam int HEADING_LAST = 3599;

    // Register indexes beyond the last real register; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_FIRST =
        CFG_IDX_W'(mch_pkg::REG_HEADING_ZERO + 1);
    localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_LAST  = '1;

    // Heading arithmetic of the unit, in 64-bit integers.
    localparam int     CORDIC_STEPS = 16;
    localparam longint FILT_ONE     = 64'sd65536;      // 1.0 with 16 fraction bits
    localparam longint FILT_HALF    = 64'sd32768;
    localparam longint FILT_KEEP    = 64'sd55706;
    localparam longint FILT_FRESH   = 64'sd9830;
    localparam int     FILT_SHIFT   = 16;
    localparam longint QUARTER_TURN = 64'sd1686629713;  // pi/2 in radians, 30 fraction bits
    localparam longint TENTHS_MUL   = 64'sd572968;
    localparam longint TENTHS_DIV   = 64'sd1073741824000; // 1000 * 2^30
    localparam longint HEAD_OFFSET  = 64'sd7200;
    localparam longint HEAD_TURN    = 64'sd3600;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [SAMPLE_W-1:0]    a;      // mag_x, or the register data
        logic [SAMPLE_W-1:0]    b;      // mag_y
        int                     known;  // heading read straight off the behaviour, or NO_CHECK
    } t_row;

    typedef enum logic [1:0] {TRAFFIC_STEADY, TRAFFIC_UNIFORM, TRAFFIC_EXTREME} t_traffic;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic signed [SAMPLE_W-1:0]   i_mag_x;
    logic signed [SAMPLE_W-1:0]   i_mag_y;
    logic                         o_out_valid;
    logic                         i_out_ready;
    logic [HEADING_W-1:0]         o_heading;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         i_cfg_index;
    logic [SAMPLE_W-1:0]          i_cfg_data;

    // Predictor state: calibration, reference heading and the two smoothed axes.
    longint               cal_x_max, cal_x_min, cal_y_max, cal_y_min;
    logic [HEADING_W-1:0] ref_zero;
    longint               filt_x, filt_y;

    logic [HEADING_W-1:0] heading_q[$];
    t_row                 plan[$];
    int                   err_count;
    int                   stall_left;
    bit                   tx_gaps_on;
    bit                   rx_stalls_on;

    magnetometer_compass_heading_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mag_x     (i_mag_x),
        .i_mag_y     (i_mag_y),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_heading   (o_heading),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // floor(atan(2^-i) * 2^30) for each CORDIC step.
    function automatic longint atan_step(input int i);
        longint val;
        case (i)
            0:       val = 64'h3243F6A8;
            1:       val = 64'h1DAC6705;
            2:       val = 64'h0FADBAFC;
            3:       val = 64'h07F56EA6;
            4:       val = 64'h03FEAB76;
            5:       val = 64'h01FFD55B;
            6:       val = 64'h00FFFAAA;
            7:       val = 64'h007FFF55;
            8:       val = 64'h003FFFEA;
            9:       val = 64'h001FFFFD;
            10:      val = 64'h000FFFFF;
            11:      val = 64'h0007FFFF;
            12:      val = 64'h0003FFFF;
            13:      val = 64'h0001FFFF;
            14:      val = 64'h0000FFFF;
            default: val = 64'h00007FFF;
        endcase
        return val;
    endfunction

    // Vectoring CORDIC giving atan2(y, x) in radians with 30 fraction bits. Vectors in the
    // left half-plane are first turned by a quarter turn so that the rotations converge.
    function automatic longint vector_angle(input longint y_in, input longint x_in);
        longint x, y, z, dx, dy, t;
        int     i;
        x = x_in;
        y = y_in;
        z = 0;
        if (x == 0 && y == 0) begin
            return 0;
        end
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = QUARTER_TURN;
            end else begin
                x = -y;
                y = t;
                z = -QUARTER_TURN;
            end
        end
        for (i = 0; i < CORDIC_STEPS; i++) begin
            // Arithmetic shifts of signed values round toward minus infinity.
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + atan_step(i);
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - atan_step(i);
            end
        end
        return z;
    endfunction

    // Takes one accepted sample through hard-iron correction, smoothing and the angle
    // computation, and returns the heading that the unit must report for it.
    function automatic logic [HEADING_W-1:0] advance_compass(
        input logic signed [SAMPLE_W-1:0] mx,
        input logic signed [SAMPLE_W-1:0] my
    );
        longint vx, vy, ang, mag, tenths, sum;
        vx = longint'(mx) * FILT_ONE - (cal_x_max + cal_x_min) * FILT_HALF;
        vy = longint'(my) * FILT_ONE - (cal_y_max + cal_y_min) * FILT_HALF;
        filt_x = (FILT_KEEP * filt_x + FILT_FRESH * vx) >>> FILT_SHIFT;
        filt_y = (FILT_KEEP * filt_y + FILT_FRESH * vy) >>> FILT_SHIFT;
        ang    = vector_angle(filt_y, filt_x);
        mag    = (ang < 0) ? -ang : ang;
        tenths = (mag * TENTHS_MUL) / TENTHS_DIV;
        if (ang < 0) begin
            tenths = -tenths;
        end
        // The offset keeps the sum positive even for a reference above 3599.
        sum = tenths - longint'(ref_zero) + HEAD_OFFSET;
        return HEADING_W'(sum % HEAD_TURN);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        err_count++;
        $display("tb_top: mismatch at %0t: %s", $realtime, what);
    endtask

    // Offers one sample and holds it until it is accepted; the expected heading is worked
    // out at the very edge at which the unit takes the item.
    task automatic send_sample(
        input logic signed [SAMPLE_W-1:0] mx,
        input logic signed [SAMPLE_W-1:0] my,
        input int                         known
    );
        logic [HEADING_W-1:0] predicted;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_mag_x    <= mx;
        i_mag_y    <= my;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = advance_compass(mx, my);
        if (known == NO_CHECK) begin
            heading_q.push_back(predicted);
        end else begin
            heading_q.push_back(HEADING_W'(known));
        end
    endtask

    // Now and then leaves the input channel empty for a burst of random length.
    task automatic maybe_gap();
        int n;
        if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 16);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Every sample causes exactly one heading, so the unit is idle once the queue of
    // expected headings has emptied.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (heading_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            mch_pkg::REG_X_MAX:        cal_x_max = longint'($signed(data));
            mch_pkg::REG_X_MIN:        cal_x_min = longint'($signed(data));
            mch_pkg::REG_Y_MAX:        cal_y_max = longint'($signed(data));
            mch_pkg::REG_Y_MIN:        cal_y_min = longint'($signed(data));
            mch_pkg::REG_HEADING_ZERO: ref_zero  = data[HEADING_W-1:0];
            default:                   ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void plan_sample(input int x, input int y, input int known);
        plan.push_back('{kind: ROW_SAMPLE, idx: '0, a: SAMPLE_W'(x), b: SAMPLE_W'(y),
                         known: known});
    endfunction

    function automatic void plan_write(input logic [CFG_IDX_W-1:0] idx, input int data);
        plan.push_back('{kind: ROW_WRITE, idx: idx, a: SAMPLE_W'(data), b: '0,
                         known: NO_CHECK});
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] clip_sample(input int v);
        if (v > SAMPLE_MAX) begin
            return SAMPLE_W'(SAMPLE_MAX);
        end
        if (v < SAMPLE_MIN) begin
            return SAMPLE_W'(SAMPLE_MIN);
        end
        return SAMPLE_W'(v);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return SAMPLE_W'(SAMPLE_MIN);
            1:       return SAMPLE_W'(-1);
            2:       return SAMPLE_W'(0);
            default: return SAMPLE_W'(SAMPLE_MAX);
        endcase
    endfunction

    // Calibration and reference heading for one phase of random traffic. The first two
    // phases pin every register to an extreme; later ones mix full-range values with
    // small offsets that leave the heading free to swing round the whole circle.
    task automatic configure_phase(input int phase);
        int k;
        settle();
        if (phase == 0) begin
            write_reg(mch_pkg::REG_X_MAX, SAMPLE_W'(SAMPLE_MAX));
            write_reg(mch_pkg::REG_X_MIN, SAMPLE_W'(SAMPLE_MAX));
            write_reg(mch_pkg::REG_Y_MAX, SAMPLE_W'(SAMPLE_MAX));
            write_reg(mch_pkg::REG_Y_MIN, SAMPLE_W'(SAMPLE_MAX));
            write_reg(mch_pkg::REG_HEADING_ZERO, SAMPLE_W'(HEADING_LAST));
        end else if (phase == 1) begin
            write_reg(mch_pkg::REG_X_MAX, SAMPLE_W'(SAMPLE_MIN));
            write_reg(mch_pkg::REG_X_MIN, SAMPLE_W'(SAMPLE_MIN));
            write_reg(mch_pkg::REG_Y_MAX, SAMPLE_W'(SAMPLE_MIN));
            write_reg(mch_pkg::REG_Y_MIN, SAMPLE_W'(SAMPLE_MIN));
            write_reg(mch_pkg::REG_HEADING_ZERO, '0);
        end else begin
            for (k = mch_pkg::REG_X_MAX; k <= mch_pkg::REG_Y_MIN; k++) begin
                if ($urandom_range(0, 1) == 0) begin
                    write_reg(CFG_IDX_W'(k), SAMPLE_W'($urandom));
                end else begin
                    write_reg(CFG_IDX_W'(k), SAMPLE_W'(int'($urandom_range(0, 4000)) - 2000));
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                write_reg(mch_pkg::REG_HEADING_ZERO, SAMPLE_W'($urandom));
            end else begin
                write_reg(mch_pkg::REG_HEADING_ZERO, SAMPLE_W'($urandom_range(0, HEADING_LAST)));
            end
            if ($urandom_range(0, 1) == 0) begin
                write_reg(CFG_IDX_W'($urandom_range(SPARE_INDEX_LAST, SPARE_INDEX_FIRST)),
                          SAMPLE_W'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: stalls in bursts of random length while stalls are enabled.
    // ------------------------------------------------------------------
    initial begin
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && rx_stalls_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 16);
            end
            if (stall_left != 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: every heading handed over is compared with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (heading_q.size() == 0) begin
                report_mismatch($sformatf("heading %0d with no item outstanding", o_heading));
            end else if (o_heading !== heading_q[0]) begin
                report_mismatch($sformatf("heading %0d, expected %0d", o_heading,
                                          heading_q[0]));
                void'(heading_q.pop_front());
            end else begin
                void'(heading_q.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run if no channel moves an item for too long.
    // ------------------------------------------------------------------
    initial begin
        int quiet;
        quiet = 0;
        @(posedge i_rst_n);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_top: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int                         phase, sent, seg_len, k, r, noise_x, noise_y;
        t_traffic                   traffic;
        logic signed [SAMPLE_W-1:0] mx, my, tx, ty;

        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_mag_x      = '0;
        i_mag_y      = '0;
        i_out_ready  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        err_count    = 0;
        cal_x_max    = 0;
        cal_x_min    = 0;
        cal_y_max    = 0;
        cal_y_min    = 0;
        ref_zero     = '0;
        filt_x       = 0;
        filt_y       = 0;
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Straight after reset the smoothed vector is zero, so the angle is
        // zero and the heading is just the offset minus the reference. A reference written
        // with all sixteen bits set keeps only its low twelve (4095, above 3599), and
        // writes to the spare indexes leave every register as it was.
        plan_sample(0, 0, 0);
        plan_write(mch_pkg::REG_HEADING_ZERO, 1800);
        plan_sample(0, 0, 1800);
        plan_write(mch_pkg::REG_HEADING_ZERO, 16'hFFFF);
        plan_sample(0, 0, 3105);
        plan_write(SPARE_INDEX_FIRST, 16'h7FFF);
        plan_write(SPARE_INDEX_LAST, 16'h8000);
        plan_sample(0, 0, 3105);
        plan_write(mch_pkg::REG_HEADING_ZERO, 0);
        // Extremes in every quadrant, including both left half-plane pre-rotations.
        plan_sample(SAMPLE_MAX, 0, NO_CHECK);
        plan_sample(SAMPLE_MIN, 0, NO_CHECK);
        plan_sample(SAMPLE_MIN, SAMPLE_MAX, NO_CHECK);
        plan_sample(SAMPLE_MIN, SAMPLE_MIN, NO_CHECK);
        plan_sample(0, SAMPLE_MIN, NO_CHECK);
        plan_sample(SAMPLE_MAX, SAMPLE_MIN, NO_CHECK);
        plan_sample(0, SAMPLE_MAX, NO_CHECK);
        plan_sample(SAMPLE_MAX, SAMPLE_MAX, NO_CHECK);
        plan_sample(0, 0, NO_CHECK);
        // Calibration centres at opposite extremes give the widest corrected values.
        plan_write(mch_pkg::REG_X_MAX, SAMPLE_MAX);
        plan_write(mch_pkg::REG_X_MIN, SAMPLE_MAX);
        plan_write(mch_pkg::REG_Y_MAX, SAMPLE_MIN);
        plan_write(mch_pkg::REG_Y_MIN, SAMPLE_MIN);
        plan_sample(SAMPLE_MAX, SAMPLE_MIN, NO_CHECK);
        plan_sample(SAMPLE_MIN, SAMPLE_MAX, NO_CHECK);
        plan_sample(0, 0, NO_CHECK);
        plan_write(mch_pkg::REG_X_MAX, SAMPLE_MIN);
        plan_write(mch_pkg::REG_X_MIN, SAMPLE_MIN);
        plan_write(mch_pkg::REG_Y_MAX, SAMPLE_MAX);
        plan_write(mch_pkg::REG_Y_MIN, SAMPLE_MAX);
        plan_sample(SAMPLE_MAX, SAMPLE_MIN, NO_CHECK);
        plan_sample(SAMPLE_MIN, SAMPLE_MAX, NO_CHECK);

        for (r = 0; r < plan.size(); r++) begin
            if (plan[r].kind == ROW_WRITE) begin
                settle();
                write_reg(plan[r].idx, plan[r].a);
            end else begin
                maybe_gap();
                send_sample(plan[r].a, plan[r].b, plan[r].known);
            end
        end

        // Random part. Most segments hold the field steady round a random direction with a
        // little noise, as a real sensor does, so the smoothed vector actually settles and
        // the heading sweeps the whole circle; the rest is uniform noise and extremes.
        for (phase = 0; phase < PHASES; phase++) begin
            configure_phase(phase);
            if (phase == PHASES - 1) begin
                tx_gaps_on   = 1'b0;
                rx_stalls_on = 1'b0;
            end else begin
                tx_gaps_on   = 1'($urandom_range(0, 1));
                rx_stalls_on = 1'($urandom_range(0, 1));
            end
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                k = $urandom_range(0, 19);
                if (k < 12) begin
                    traffic = TRAFFIC_STEADY;
                end else if (k < 17) begin
                    traffic = TRAFFIC_UNIFORM;
                end else begin
                    traffic = TRAFFIC_EXTREME;
                end
                seg_len = $urandom_range(1, 20);
                tx = SAMPLE_W'($urandom);
                ty = SAMPLE_W'($urandom);
                for (k = 0; k < seg_len && sent < ITEMS_PER_PHASE; k++) begin
                    case (traffic)
                        TRAFFIC_STEADY: begin
                            noise_x = int'($urandom_range(0, 512)) - 256;
                            noise_y = int'($urandom_range(0, 512)) - 256;
                            mx = clip_sample(int'(tx) + noise_x);
                            my = clip_sample(int'(ty) + noise_y);
                        end
                        TRAFFIC_UNIFORM: begin
                            mx = SAMPLE_W'($urandom);
                            my = SAMPLE_W'($urandom);
                        end
                        default: begin
                            mx = pick_extreme();
                            my = pick_extreme();
                        end
                    endcase
                    maybe_gap();
                    send_sample(mx, my, NO_CHECK);
                    sent++;
                end
            end
        end

        // Drain, then give any stray heading time to show up before the verdict.
        settle();
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
